@@ hdl/lhsr_pkg.sv @@
// shared types and constants for the letter histogram sorted report unit
`timescale 1ns / 1ps

package lhsr_pkg;

   localparam int CHAR_WIDTH   = 8;
   localparam int LETTER_WIDTH = 5;
   localparam int RSP_COUNT_WIDTH = 8;

   localparam logic [CHAR_WIDTH-1:0] UPPER_BELOW = 8'd64;
   localparam logic [CHAR_WIDTH-1:0] UPPER_ABOVE = 8'd91;
   localparam logic [CHAR_WIDTH-1:0] LOWER_BELOW = 8'd96;
   localparam logic [CHAR_WIDTH-1:0] LOWER_ABOVE = 8'd123;
   localparam logic [CHAR_WIDTH-1:0] UPPER_BASE  = 8'd65;
   localparam logic [CHAR_WIDTH-1:0] LOWER_BASE  = 8'd97;

   localparam logic [RSP_COUNT_WIDTH-1:0] RSP_COUNT_MAX = 8'd255;

   localparam logic PHASE_BY_COUNT = 1'b0;
   localparam logic PHASE_ALPHA    = 1'b1;

   typedef struct packed {
      logic count_en;
      logic begin_report;
      logic pass_next;
      logic scan_restart;
      logic scan_adv;
      logic emit_by_count;
      logic emit_alpha;
      logic clear_all;
   } lhsr_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic next_found;
      logic cur_zero;
   } lhsr_stat_type;

endpackage

@@ hdl/lhsr_datapath.sv @@
// letter counters, report scan, threshold tracking and result register
`timescale 1ns / 1ps

module lhsr_datapath #(
   parameter int NUM_LETTERS = 26,
   parameter int COUNT_WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lhsr_pkg::lhsr_cmd_type                 cmd,
   output lhsr_pkg::lhsr_stat_type                stat,
   input  logic [lhsr_pkg::CHAR_WIDTH-1:0]        req_char_code,
   output logic                                   rsp_valid,
   output logic [lhsr_pkg::LETTER_WIDTH-1:0]      rsp_letter,
   output logic [lhsr_pkg::RSP_COUNT_WIDTH-1:0]   rsp_count,
   output logic                                   rsp_phase,
   output logic                                   rsp_last
);

   localparam int IDX_W = (NUM_LETTERS > 1) ? $clog2(NUM_LETTERS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_LETTERS - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] counts_ff [NUM_LETTERS];
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [COUNT_WIDTH-1:0] cur_ff, cur_in;
   logic [COUNT_WIDTH-1:0] min_ff, min_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       last_nz_ff, last_nz_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [lhsr_pkg::LETTER_WIDTH-1:0]    rsp_letter_ff, rsp_letter_in;
   logic [lhsr_pkg::RSP_COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_phase_ff, rsp_phase_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   is_upper, is_lower, letter_ok;
   logic [lhsr_pkg::LETTER_WIDTH-1:0] code_idx;
   logic [COUNT_WIDTH-1:0] cnt_sel;
   logic [COUNT_WIDTH+7:0] cnt_wide;
   logic                   cnt_nz, above_cur, take_new;
   logic [COUNT_WIDTH-1:0] next_val;
   logic                   any_nz;

   // letter decode
   always_comb begin
      is_upper = (req_char_code > lhsr_pkg::UPPER_BELOW) &&
                 (req_char_code < lhsr_pkg::UPPER_ABOVE);
      is_lower = (req_char_code > lhsr_pkg::LOWER_BELOW) &&
                 (req_char_code < lhsr_pkg::LOWER_ABOVE);
      if (is_upper) begin
         code_idx = lhsr_pkg::LETTER_WIDTH'(req_char_code - lhsr_pkg::UPPER_BASE);
      end else begin
         code_idx = lhsr_pkg::LETTER_WIDTH'(req_char_code - lhsr_pkg::LOWER_BASE);
      end
      letter_ok = (is_upper || is_lower) &&
                  ({1'b0, code_idx} < (lhsr_pkg::LETTER_WIDTH + 1)'(NUM_LETTERS));
   end

   // saturating bins
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
         if (reset || cmd.clear_all) begin
            counts_ff[i] <= '0;
         end else if (cmd.count_en && letter_ok &&
                      (code_idx == lhsr_pkg::LETTER_WIDTH'(i)) &&
                      (counts_ff[i] != COUNT_FULL)) begin
            counts_ff[i] <= counts_ff[i] + 1'b1;
         end
      end
   end

   // scan element and threshold tracking
   always_comb begin
      cnt_sel   = counts_ff[scan_idx_ff];
      cnt_wide  = (COUNT_WIDTH + 8)'(cnt_sel);
      cnt_nz    = (cnt_sel != '0);
      above_cur = (cnt_sel > cur_ff);
      take_new  = above_cur && (!found_ff || (cnt_sel < min_ff));
      next_val  = take_new ? cnt_sel : min_ff;

      stat.scan_end   = (scan_idx_ff == IDX_LAST);
      stat.next_found = found_ff || above_cur;
      stat.cur_zero   = (cur_ff == '0);

      scan_idx_in = scan_idx_ff;
      cur_in      = cur_ff;
      min_in      = min_ff;
      found_in    = found_ff;
      last_nz_in  = last_nz_ff;

      if (cmd.scan_adv) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         min_in      = next_val;
         found_in    = found_ff || above_cur;
         // highest nonzero bin, settled by the frequency passes
         if (cnt_nz && cmd.emit_by_count) begin
            last_nz_in = scan_idx_ff;
         end
      end
      if (cmd.pass_next) begin
         cur_in = next_val;
      end
      if (cmd.begin_report) begin
         cur_in = '0;
      end
      if (cmd.scan_restart || cmd.begin_report) begin
         scan_idx_in = '0;
         min_in      = '0;
         found_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         cur_ff      <= '0;
         min_ff      <= '0;
         found_ff    <= 1'b0;
         last_nz_ff  <= '0;
      end else begin
         scan_idx_ff <= scan_idx_in;
         cur_ff      <= cur_in;
         min_ff      <= min_in;
         found_ff    <= found_in;
         last_nz_ff  <= last_nz_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_letter_in = lhsr_pkg::LETTER_WIDTH'(scan_idx_ff);
      rsp_count_in  = (cnt_wide > (COUNT_WIDTH + 8)'(lhsr_pkg::RSP_COUNT_MAX)) ?
                      lhsr_pkg::RSP_COUNT_MAX : cnt_wide[7:0];
      rsp_phase_in  = lhsr_pkg::PHASE_BY_COUNT;
      rsp_last_in   = 1'b0;
      if (cmd.emit_by_count && cnt_nz && (cnt_sel == cur_ff)) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.emit_alpha && cnt_nz) begin
         rsp_valid_in = 1'b1;
         rsp_phase_in = lhsr_pkg::PHASE_ALPHA;
         rsp_last_in  = (scan_idx_ff == last_nz_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_letter_ff <= rsp_letter_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_letter = rsp_letter_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_phase  = rsp_phase_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      any_nz = 1'b0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
         any_nz = any_nz || (counts_ff[i] != '0);
      end
   end

   a_rsp_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0))
      else $error("result transfer with zero count");

   a_by_count_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_phase_ff == lhsr_pkg::PHASE_BY_COUNT)) |-> !rsp_last_ff)
      else $error("last flag on frequency report result");

   a_cleared_after_report: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> !any_nz)
      else $error("bins not cleared after report");

endmodule

@@ hdl/lhsr_controller.sv @@
// state machine sequencing counting, frequency passes and alphabetical pass
`timescale 1ns / 1ps

module lhsr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    req_is_last,
   input  lhsr_pkg::lhsr_stat_type stat,
   output lhsr_pkg::lhsr_cmd_type  cmd,
   output logic                    busy
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FREQ  = 2'd1;
   localparam logic [1:0] ST_ALPHA = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.count_en = 1'b1;
               if (req_is_last) begin
                  cmd.begin_report = 1'b1;
                  state_in         = ST_FREQ;
               end
            end
         end
         ST_FREQ: begin
            cmd.emit_by_count = 1'b1;
            cmd.scan_adv      = 1'b1;
            if (stat.scan_end) begin
               if (stat.next_found) begin
                  cmd.pass_next    = 1'b1;
                  cmd.scan_restart = 1'b1;
               end else if (stat.cur_zero) begin
                  cmd.clear_all    = 1'b1;
                  cmd.scan_restart = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  cmd.scan_restart = 1'b1;
                  state_in         = ST_ALPHA;
               end
            end
         end
         ST_ALPHA: begin
            cmd.emit_alpha = 1'b1;
            cmd.scan_adv   = 1'b1;
            if (stat.scan_end) begin
               cmd.clear_all    = 1'b1;
               cmd.scan_restart = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_alpha_ends_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ALPHA) && stat.scan_end) |=> (state_ff == ST_IDLE))
      else $error("alphabetical pass did not finish");

   a_report_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_last) |=> (state_ff == ST_FREQ))
      else $error("report not started on last byte");

   a_no_count_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.count_en)
      else $error("byte counted during report");

endmodule

@@ hdl/letter_histogram_sorted_report_unit.sv @@
// Letter histogram with frequency-sorted and alphabetical run reports
// Bytes: one per cycle while busy is low, counted in the cycle of the transfer.
// Report after the last byte: busy stays high for the frequency passes, whose number follows
// the distinct nonzero counts, and the alphabetical pass, one scan of the bins per pass; each
// result appears on the result ports in the cycle after its scan step.
// Empty string: one scan of the bins and no results; reset clears bins, goes idle.
`timescale 1ns / 1ps

module letter_histogram_sorted_report_unit #(
   parameter int NUM_LETTERS = 26,
   parameter int COUNT_WIDTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [lhsr_pkg::CHAR_WIDTH-1:0]      req_char_code,
   input  logic                                 req_is_last,
   output logic                                 rsp_valid,
   output logic [lhsr_pkg::LETTER_WIDTH-1:0]    rsp_letter,
   output logic [lhsr_pkg::RSP_COUNT_WIDTH-1:0] rsp_count,
   output logic                                 rsp_phase,
   output logic                                 rsp_last
);

   lhsr_pkg::lhsr_cmd_type  cmd;
   lhsr_pkg::lhsr_stat_type stat;
   logic                    accept;

   assign accept = start && !busy;

   lhsr_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_is_last (req_is_last),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   lhsr_datapath #(
      .NUM_LETTERS (NUM_LETTERS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_letter    (rsp_letter),
      .rsp_count     (rsp_count),
      .rsp_phase     (rsp_phase),
      .rsp_last      (rsp_last)
   );

endmodule

@@ verif/lhsr_checker.sv @@
// checker for the letter histogram report unit: predicts each report and compares the result port
`timescale 1ns / 1ps

module lhsr_checker #(
   parameter int NUM_LETTERS = 26,
   parameter int COUNT_WIDTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [lhsr_pkg::CHAR_WIDTH-1:0]      req_char_code,
   input  logic                                 req_is_last,
   input  logic                                 rsp_valid,
   input  logic [lhsr_pkg::LETTER_WIDTH-1:0]    rsp_letter,
   input  logic [lhsr_pkg::RSP_COUNT_WIDTH-1:0] rsp_count,
   input  logic                                 rsp_phase,
   input  logic                                 rsp_last,
   output int                                   error_count,
   output int                                   pending_count
);

   localparam logic [COUNT_WIDTH-1:0] BIN_MAX = '1;

   typedef struct packed {
      logic [lhsr_pkg::LETTER_WIDTH-1:0]    letter;
      logic [lhsr_pkg::RSP_COUNT_WIDTH-1:0] count;
      logic                                 phase;
      logic                                 last;
   } report_entry_type;

   logic [COUNT_WIDTH-1:0] letter_bins [NUM_LETTERS];
   report_entry_type       report_due [$];

   function automatic logic [lhsr_pkg::RSP_COUNT_WIDTH-1:0] clip_count(
      logic [COUNT_WIDTH-1:0] bin);
      if (bin > lhsr_pkg::RSP_COUNT_MAX) return lhsr_pkg::RSP_COUNT_MAX;
      return lhsr_pkg::RSP_COUNT_WIDTH'(bin);
   endfunction

   function automatic report_entry_type make_entry(int idx, logic phase);
      report_entry_type entry;
      entry.letter = lhsr_pkg::LETTER_WIDTH'(idx);
      entry.count  = clip_count(letter_bins[idx]);
      entry.phase  = phase;
      entry.last   = 1'b0;
      return entry;
   endfunction

   // count one byte; on the last byte queue the by-count list then the alphabetical runs
   task automatic tally_byte(logic [lhsr_pkg::CHAR_WIDTH-1:0] code, logic is_last);
      int idx;
      int pos;
      int ranked [$];
      report_entry_type burst [$];
      idx = -1;
      if (code > lhsr_pkg::UPPER_BELOW && code < lhsr_pkg::UPPER_ABOVE) begin
         idx = int'(code - lhsr_pkg::UPPER_BASE);
      end else if (code > lhsr_pkg::LOWER_BELOW && code < lhsr_pkg::LOWER_ABOVE) begin
         idx = int'(code - lhsr_pkg::LOWER_BASE);
      end
      if (idx >= 0 && idx < NUM_LETTERS && letter_bins[idx] != BIN_MAX) begin
         letter_bins[idx] = letter_bins[idx] + 1'b1;
      end
      if (!is_last) return;
      // stable insertion keeps alphabetical order among equal counts
      for (int i = 0; i < NUM_LETTERS; i++) begin
         if (letter_bins[i] != '0) begin
            pos = ranked.size();
            while (pos > 0 && letter_bins[ranked[pos-1]] > letter_bins[i]) pos--;
            ranked.insert(pos, i);
         end
      end
      foreach (ranked[k]) burst.push_back(make_entry(ranked[k], lhsr_pkg::PHASE_BY_COUNT));
      for (int i = 0; i < NUM_LETTERS; i++) begin
         if (letter_bins[i] != '0) burst.push_back(make_entry(i, lhsr_pkg::PHASE_ALPHA));
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[k]) report_due.push_back(burst[k]);
      for (int i = 0; i < NUM_LETTERS; i++) letter_bins[i] = '0;
   endtask

   function automatic bit field_ok(string name, int want, int got);
      if (want == got) return 1'b1;
      $display("%0t ns: rsp_%s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      report_entry_type want;
      bit ok;
      if (reset) begin
         for (int i = 0; i < NUM_LETTERS; i++) letter_bins[i] = '0;
         report_due.delete();
         error_count = 0;
      end else begin
         if (start && !busy) tally_byte(req_char_code, req_is_last);
         if (rsp_valid) begin
            if (report_due.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual letter %0d count %0d",
                        $time, rsp_letter, rsp_count);
               error_count++;
            end else begin
               want = report_due.pop_front();
               ok = field_ok("letter", want.letter, rsp_letter)
                  & field_ok("count", want.count, rsp_count)
                  & field_ok("phase", want.phase, rsp_phase)
                  & field_ok("last", want.last, rsp_last);
               if (!ok) error_count++;
            end
         end
      end
      pending_count = report_due.size();
   end

endmodule

@@ verif/letter_histogram_sorted_report_unit_tb.sv @@
// testbench top for the letter histogram report unit: stimulus, checker hookup and verdict
`timescale 1ns / 1ps

module letter_histogram_sorted_report_unit_tb;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [lhsr_pkg::CHAR_WIDTH-1:0]      req_char_code;
   logic                                 req_is_last;
   logic                                 rsp_valid;
   logic [lhsr_pkg::LETTER_WIDTH-1:0]    rsp_letter;
   logic [lhsr_pkg::RSP_COUNT_WIDTH-1:0] rsp_count;
   logic                                 rsp_phase;
   logic                                 rsp_last;
   int                                   error_count;
   int                                   pending_count;
   int                                   burst_left;

   letter_histogram_sorted_report_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_letter    (rsp_letter),
      .rsp_count     (rsp_count),
      .rsp_phase     (rsp_phase),
      .rsp_last      (rsp_last)
   );

   lhsr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_letter    (rsp_letter),
      .rsp_count     (rsp_count),
      .rsp_phase     (rsp_phase),
      .rsp_last      (rsp_last),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [lhsr_pkg::CHAR_WIDTH-1:0] letter_code(int idx);
      return ($urandom_range(0, 1) ? lhsr_pkg::UPPER_BASE : lhsr_pkg::LOWER_BASE) +
             lhsr_pkg::CHAR_WIDTH'(idx);
   endfunction

   function automatic logic [lhsr_pkg::CHAR_WIDTH-1:0] noise_code();
      case ($urandom_range(0, 2))
         0:       return lhsr_pkg::CHAR_WIDTH'($urandom_range(0, lhsr_pkg::UPPER_BELOW));
         1:       return lhsr_pkg::CHAR_WIDTH'($urandom_range(lhsr_pkg::UPPER_ABOVE,
                                                              lhsr_pkg::LOWER_BELOW));
         default: return lhsr_pkg::CHAR_WIDTH'($urandom_range(lhsr_pkg::LOWER_ABOVE, 255));
      endcase
   endfunction

   task automatic send_byte(logic [lhsr_pkg::CHAR_WIDTH-1:0] code, logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start         <= 1'b1;
      req_char_code <= code;
      req_is_last   <= is_last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_text(logic [lhsr_pkg::CHAR_WIDTH-1:0] text [$]);
      foreach (text[k]) send_byte(text[k], k == text.size() - 1);
   endtask

   initial begin
      logic [lhsr_pkg::CHAR_WIDTH-1:0] text [$];
      int pool [$];
      int random_items;
      int kind;
      int len;
      int hot;
      bit saturation_sent;
      reset         = 1'b1;
      start         = 1'b0;
      req_char_code = '0;
      req_is_last   = 1'b0;
      burst_left    = 0;
      random_items  = 0;
      saturation_sent = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reports, range edges, single letter, mixed case, ties
      send_text('{8'd0});
      send_text('{lhsr_pkg::UPPER_BASE});
      send_text('{lhsr_pkg::UPPER_BELOW, lhsr_pkg::UPPER_ABOVE, lhsr_pkg::LOWER_BELOW,
                  lhsr_pkg::LOWER_ABOVE});
      send_text('{lhsr_pkg::UPPER_BASE + 8'd25, lhsr_pkg::LOWER_BASE,
                  lhsr_pkg::LOWER_BASE + 8'd25, lhsr_pkg::UPPER_BASE,
                  lhsr_pkg::LOWER_BASE + 8'd25, 8'd255});
      send_text('{lhsr_pkg::LOWER_BASE + 8'd1, lhsr_pkg::UPPER_BASE + 8'd1,
                  lhsr_pkg::LOWER_BASE + 8'd2, lhsr_pkg::LOWER_BASE});

      while (random_items < 380) begin
         text.delete();
         pool.delete();
         if (!saturation_sent && random_items > 150) begin
            // one dominant letter in a long text, aimed at the count ceiling
            hot = $urandom_range(0, 25);
            repeat (262) begin
               text.push_back(($urandom_range(0, 15) == 0) ?
                              letter_code($urandom_range(0, 25)) : letter_code(hot));
            end
            saturation_sent = 1'b1;
         end else begin
            kind = $urandom_range(0, 9);
            case (kind)
               5: begin
                  repeat ($urandom_range(1, 10)) begin
                     text.push_back(lhsr_pkg::CHAR_WIDTH'($urandom_range(0, 255)));
                  end
               end
               6: begin
                  for (int i = 0; i < 26; i++) begin
                     repeat ($urandom_range(1, 3)) text.push_back(letter_code(i));
                  end
                  repeat ($urandom_range(0, 4)) text.push_back(letter_code($urandom_range(0, 25)));
               end
               7: begin
                  repeat ($urandom_range(1, 4)) text.push_back(noise_code());
               end
               default: begin
                  if (kind >= 8) begin
                     repeat ($urandom_range(1, 2)) pool.push_back($urandom_range(0, 25));
                     len = $urandom_range(10, 30);
                  end else begin
                     repeat ($urandom_range(1, 6)) pool.push_back($urandom_range(0, 25));
                     len = $urandom_range(1, 14);
                  end
                  repeat (len) begin
                     text.push_back(($urandom_range(0, 6) == 0) ?
                                    lhsr_pkg::CHAR_WIDTH'($urandom_range(0, 255)) :
                                    letter_code(pool[$urandom_range(0, pool.size() - 1)]));
                  end
               end
            endcase
         end
         random_items += text.size();
         send_text(text);
      end
      start <= 1'b0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (800) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
